[rtl/core/i4dw_pkg.sv]
package i4dw_pkg;

	localparam int ACT_W     = 8;
	localparam int WBYTE_W   = 8;
	localparam int NIB_W     = 4;
	localparam int IOFF_W    = 9;
	localparam int OOFF_W    = 8;
	localparam int ACC_W     = 32;
	localparam int BIAS_W    = 32;
	localparam int MULT_W    = 31;
	localparam int SHIFT_W   = 6;
	localparam int OUT_W     = 8;
	localparam int BIAS_RSH  = 4;
	localparam int BIAS_HI_W = BIAS_W - BIAS_RSH;
	localparam int ASUM_W    = 10;
	localparam int PROD_W    = ASUM_W + NIB_W;

	localparam int S_TDATA_W = 88;
	localparam int S_TUSER_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_IN_OFS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_OFS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACT_MIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACT_MAX = 2'd3;

	localparam logic signed [63:0] NUDGE_POS = 64'sh0000_0000_4000_0000;
	localparam logic signed [63:0] NUDGE_NEG = 64'shFFFF_FFFF_C000_0001;

	typedef struct packed {
		logic signed [IOFF_W-1:0] in_ofs;
		logic signed [OOFF_W-1:0] out_ofs;
		logic signed [OUT_W-1:0]  act_min;
		logic signed [OUT_W-1:0]  act_max;
	} cfg_t;

	typedef struct packed {
		logic signed [PROD_W-1:0]    prod;
		logic                        first;
		logic                        last;
		logic signed [BIAS_HI_W-1:0] bias_hi;
		logic [MULT_W-1:0]           mult;
		logic signed [SHIFT_W-1:0]   shift;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [2:0] {
		BK_ACC,
		BK_SHIFT,
		BK_MUL,
		BK_NUDGE,
		BK_QUOT,
		BK_ROUND,
		BK_OUT
	} back_state_t;

endpackage

[rtl/core/int4_depthwise_mac_requant.sv]
// One output channel of a quantized depthwise convolution with packed signed 4-bit weights,
// fed one filter tap per transaction. The front end registers a tap and forms its
// (activation + input offset) * weight product; a two-entry queue feeds the back end,
// which adds one tap per cycle into the 32-bit accumulator while it is accumulating and the
// queue is not empty. A last tap is accumulated and then takes the back end through left
// shift, 32x32 multiply, rounding nudge, quotient, rounding right shift, and offset and clamp,
// which waits for the output register to be free; no tap leaves the queue meanwhile. The front
// end keeps accepting taps while its register is empty or the queue has room. Configuration
// writes are taken in every cycle and must only be issued while no tap is in flight.
module int4_depthwise_mac_requant (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [i4dw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [i4dw_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// activation[7:0], weight_byte[15:8], bias[47:16], out_multiplier[78:48],
	// out_shift[84:79], zero fill[87:85]
	input  logic [i4dw_pkg::S_TDATA_W-1:0]       s_tdata,
	// in_bounds[0], high_nibble[1], first_tap[2]
	input  logic [i4dw_pkg::S_TUSER_W-1:0]       s_tuser,
	// last_tap
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// out_value[7:0]
	output logic [i4dw_pkg::OUT_W-1:0]           m_tdata
);

	i4dw_pkg::cfg_t       cfg_q;
	i4dw_pkg::q_status_t  q_status;
	i4dw_pkg::entry_t     push_entry;
	i4dw_pkg::entry_t     head;
	logic                 push;
	logic                 pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_ofs  <= '0;
			cfg_q.out_ofs <= '0;
			cfg_q.act_min <= 8'sh80;
			cfg_q.act_max <= 8'sh7F;
		end else if (cfg_valid) begin
			case (cfg_index)
				i4dw_pkg::REG_IN_OFS:  cfg_q.in_ofs  <= cfg_data;
				i4dw_pkg::REG_OUT_OFS: cfg_q.out_ofs <= cfg_data[7:0];
				i4dw_pkg::REG_ACT_MIN: cfg_q.act_min <= cfg_data[7:0];
				i4dw_pkg::REG_ACT_MAX: cfg_q.act_max <= cfg_data[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	i4dw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	i4dw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	i4dw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[rtl/core/i4dw_front.sv]
module i4dw_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  i4dw_pkg::cfg_t                      cfg,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [i4dw_pkg::S_TDATA_W-1:0]      s_tdata,
	input  logic [i4dw_pkg::S_TUSER_W-1:0]      s_tuser,
	input  logic                                s_tlast,
	input  i4dw_pkg::q_status_t                 q_status,
	output logic                                push,
	output i4dw_pkg::entry_t                    push_entry
);

	logic                                        v_s1;
	i4dw_pkg::entry_t                            ent_s1;
	i4dw_pkg::entry_t                            ent_new;
	logic signed [i4dw_pkg::ACT_W-1:0]           act;
	logic [i4dw_pkg::WBYTE_W-1:0]                wbyte;
	logic signed [i4dw_pkg::NIB_W-1:0]           wnib;
	logic signed [i4dw_pkg::ASUM_W-1:0]          act_sum;
	logic signed [i4dw_pkg::PROD_W-1:0]          prod;
	logic                                        accept;

	assign act   = s_tdata[7:0];
	assign wbyte = s_tdata[15:8];
	assign wnib  = s_tuser[1] ? wbyte[7:4] : wbyte[3:0];

	always_comb begin
		act_sum = {{(i4dw_pkg::ASUM_W-i4dw_pkg::ACT_W){act[i4dw_pkg::ACT_W-1]}}, act}
			+ {{(i4dw_pkg::ASUM_W-i4dw_pkg::IOFF_W){cfg.in_ofs[i4dw_pkg::IOFF_W-1]}},
			cfg.in_ofs};
		prod = (i4dw_pkg::PROD_W)'(act_sum) * (i4dw_pkg::PROD_W)'(wnib);
		ent_new.prod    = s_tuser[0] ? prod : '0;
		ent_new.first   = s_tuser[2];
		ent_new.last    = s_tlast;
		ent_new.bias_hi = s_tdata[47:16+i4dw_pkg::BIAS_RSH];
		ent_new.mult    = s_tdata[78:48];
		ent_new.shift   = s_tdata[84:79];
	end

	assign push     = v_s1 && !q_status.full;
	assign s_tready = !v_s1 || !q_status.full;
	assign accept   = s_tvalid && s_tready;
	assign push_entry = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1 <= ent_new;
		end
	end

endmodule

[rtl/core/i4dw_queue.sv]
module i4dw_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  i4dw_pkg::entry_t     push_entry,
	input  logic                 pop,
	output i4dw_pkg::entry_t     head,
	output i4dw_pkg::q_status_t  q_status
);

	i4dw_pkg::entry_t                 mem_q [i4dw_pkg::QDEPTH];
	logic [i4dw_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [i4dw_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [i4dw_pkg::QPTR_W:0]        count_q;

	assign head           = mem_q[rd_ptr_q];
	assign q_status.full  = count_q == (i4dw_pkg::QPTR_W+1)'(i4dw_pkg::QDEPTH);
	assign q_status.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[rtl/core/i4dw_back.sv]
module i4dw_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  i4dw_pkg::cfg_t                 cfg,
	input  i4dw_pkg::entry_t               head,
	input  i4dw_pkg::q_status_t            q_status,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [i4dw_pkg::OUT_W-1:0]     m_tdata
);

	i4dw_pkg::back_state_t                 state_q;
	i4dw_pkg::back_state_t                 state_nxt;
	logic                                  load_out;
	logic [i4dw_pkg::ACC_W-1:0]            acc_q;
	logic [i4dw_pkg::ACC_W-1:0]            acc_base;
	logic [i4dw_pkg::ACC_W-1:0]            acc_nxt;
	logic [i4dw_pkg::MULT_W-1:0]           mult_q;
	logic [4:0]                            ls_q;
	logic [5:0]                            rs_q;
	logic signed [31:0]                    x_q;
	logic signed [63:0]                    ab_q;
	logic signed [63:0]                    s_q;
	logic [31:0]                           hm_q;
	logic signed [32:0]                    r_q;
	logic [32:0]                           quot;
	logic [32:0]                           mask;
	logic [32:0]                           rem;
	logic [32:0]                           thr;
	logic signed [32:0]                    shifted;
	logic signed [32:0]                    rounded;
	logic signed [33:0]                    v;
	logic signed [33:0]                    vmin;
	logic signed [33:0]                    vmax;
	logic signed [33:0]                    clamped;
	logic                                  m_valid_q;
	logic [i4dw_pkg::OUT_W-1:0]            out_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			i4dw_pkg::BK_ACC: begin
				if (!q_status.empty && head.last) begin
					state_nxt = i4dw_pkg::BK_SHIFT;
				end
			end
			i4dw_pkg::BK_SHIFT: state_nxt = i4dw_pkg::BK_MUL;
			i4dw_pkg::BK_MUL:   state_nxt = i4dw_pkg::BK_NUDGE;
			i4dw_pkg::BK_NUDGE: state_nxt = i4dw_pkg::BK_QUOT;
			i4dw_pkg::BK_QUOT:  state_nxt = i4dw_pkg::BK_ROUND;
			i4dw_pkg::BK_ROUND: state_nxt = i4dw_pkg::BK_OUT;
			i4dw_pkg::BK_OUT: begin
				if (!m_valid_q || m_tready) begin
					state_nxt = i4dw_pkg::BK_ACC;
				end
			end
			default: state_nxt = i4dw_pkg::BK_ACC;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			i4dw_pkg::BK_ACC: pop      = !q_status.empty;
			i4dw_pkg::BK_OUT: load_out = !m_valid_q || m_tready;
			default: begin
				pop      = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_comb begin
		acc_base = head.first
			? {{(i4dw_pkg::ACC_W-i4dw_pkg::BIAS_HI_W){head.bias_hi[i4dw_pkg::BIAS_HI_W-1]}},
			head.bias_hi}
			: acc_q;
		acc_nxt = acc_base
			+ {{(i4dw_pkg::ACC_W-i4dw_pkg::PROD_W){head.prod[i4dw_pkg::PROD_W-1]}}, head.prod};

		quot = s_q[63:31] + {32'd0, s_q[63] && (s_q[30:0] != '0)};

		mask    = (33'd1 << rs_q) - 33'd1;
		rem     = {1'b0, hm_q} & mask;
		thr     = (mask >> 1) + {32'd0, hm_q[31]};
		shifted = $signed({hm_q[31], hm_q}) >>> rs_q;
		rounded = shifted + $signed({32'd0, rem > thr});

		v    = {r_q[32], r_q} + {{26{cfg.out_ofs[7]}}, cfg.out_ofs};
		vmin = {{26{cfg.act_min[7]}}, cfg.act_min};
		vmax = {{26{cfg.act_max[7]}}, cfg.act_max};
		clamped = v;
		if (clamped < vmin) begin
			clamped = vmin;
		end
		if (clamped > vmax) begin
			clamped = vmax;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= i4dw_pkg::BK_ACC;
			acc_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (pop) begin
				acc_q <= acc_nxt;
			end
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mult_q <= head.mult;
			ls_q   <= head.shift[5] ? 5'd0 : head.shift[4:0];
			rs_q   <= head.shift[5] ? 6'(-head.shift) : 6'd0;
		end
		if (state_q == i4dw_pkg::BK_SHIFT) begin
			x_q <= $signed(acc_q << ls_q);
		end
		if (state_q == i4dw_pkg::BK_MUL) begin
			ab_q <= 64'(x_q) * 64'($signed({1'b0, mult_q}));
		end
		if (state_q == i4dw_pkg::BK_NUDGE) begin
			s_q <= ab_q + (ab_q[63] ? i4dw_pkg::NUDGE_NEG : i4dw_pkg::NUDGE_POS);
		end
		if (state_q == i4dw_pkg::BK_QUOT) begin
			hm_q <= quot[31:0];
		end
		if (state_q == i4dw_pkg::BK_ROUND) begin
			r_q <= rounded;
		end
		if (load_out) begin
			out_q <= clamped[i4dw_pkg::OUT_W-1:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q;

endmodule

[rtl/core/i4dw_checker.sv]
module i4dw_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [i4dw_pkg::OUT_W-1:0]     m_tdata
);

	// last taps accepted but not yet delivered
	logic [3:0] pending_q;
	logic       in_last;
	logic       out_xfer;

	assign in_last  = s_tvalid && s_tready && s_tlast;
	assign out_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_last && !out_xfer) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_xfer && !in_last) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 4'd0)
		else $error("result without an accepted last tap");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'd5)
		else $error("more last taps in flight than the pipeline holds");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid during reset");

endmodule

bind int4_depthwise_mac_requant i4dw_checker u_i4dw_checker (.*);

[test/tb_int4_depthwise_mac_requant.sv]
`timescale 1ns / 1ps

module tb_int4_depthwise_mac_requant;
	import i4dw_pkg::*;

	localparam logic [MULT_W-1:0] MULT_MAX = 31'h7fff_ffff;
	localparam int DRAIN_CYCLES = 24;

	typedef struct {
		logic signed [ACT_W-1:0]   act;
		logic                      inb;
		logic [WBYTE_W-1:0]        wbyte;
		logic                      hi;
		logic                      first;
		logic                      last;
		logic signed [BIAS_W-1:0]  bias;
		logic [MULT_W-1:0]         mult;
		logic signed [SHIFT_W-1:0] shift;
	} tap_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	logic signed [IOFF_W-1:0] ioff_model = '0;
	logic signed [OOFF_W-1:0] ooff_model = '0;
	logic signed [OUT_W-1:0] min_model = 8'h80;
	logic signed [OUT_W-1:0] max_model = 8'h7f;
	logic [ACC_W-1:0] acc_model = '0;
	logic [OUT_W-1:0] expected_out[$];

	int errors = 0;
	bit tx_gaps = 1'b1;
	bit rx_stalls = 1'b1;
	int rx_hold = 0;
	int rx_burst = 0;

	int4_depthwise_mac_requant dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void report_error(input string what, input logic [OUT_W-1:0] want,
		input logic [OUT_W-1:0] got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s: expected %0d, got %0d", $time, what, $signed(want), $signed(got));
	endfunction

	function automatic void predict_tap(input tap_t t);
		logic [NIB_W-1:0] nib;
		logic signed [NIB_W-1:0] w;
		logic [ACC_W-1:0] shifted;
		int sh;
		int prod;
		longint ab, nudge, hm, mask, rem, thr, v;
		if (t.first)
			acc_model = t.bias >>> BIAS_RSH;
		if (t.inb) begin
			nib = t.hi ? t.wbyte[7:4] : t.wbyte[3:0];
			w = nib;
			prod = (int'(t.act) + int'(ioff_model)) * int'(w);
			acc_model = acc_model + prod;
		end
		if (!t.last)
			return;
		sh = int'(t.shift);
		shifted = acc_model << ((sh > 0) ? sh : 0);
		ab = longint'($signed(shifted)) * longint'(t.mult);
		nudge = (ab >= 0) ? (longint'(1) << 30) : (longint'(1) - (longint'(1) << 30));
		hm = longint'(int'((ab + nudge) / (longint'(1) << 31)));
		sh = (sh > 0) ? 0 : -sh;
		mask = (longint'(1) << sh) - 1;
		rem = hm & mask;
		thr = (mask >>> 1) + ((hm < 0) ? 1 : 0);
		v = (hm >>> sh) + ((rem > thr) ? 1 : 0) + longint'(ooff_model);
		if (v < longint'(min_model))
			v = longint'(min_model);
		if (v > longint'(max_model))
			v = longint'(max_model);
		expected_out.push_back(v[OUT_W-1:0]);
	endfunction

	function automatic tap_t mk_tap(input logic [7:0] act, input bit inb, input logic [7:0] wbyte,
		input bit hi, input bit first, input bit last, input logic [31:0] bias,
		input logic [30:0] mult, input int shift);
		tap_t t;
		t.act = act;
		t.inb = inb;
		t.wbyte = wbyte;
		t.hi = hi;
		t.first = first;
		t.last = last;
		t.bias = bias;
		t.mult = mult;
		t.shift = SHIFT_W'(shift);
		return t;
	endfunction

	function automatic tap_t rand_tap(input bit first, input bit last);
		tap_t t;
		t.act = ACT_W'($urandom);
		t.inb = $urandom_range(0, 4) != 0;
		t.wbyte = WBYTE_W'($urandom);
		t.hi = 1'($urandom_range(0, 1));
		t.first = first;
		t.last = last;
		if ($urandom_range(0, 3) == 0) begin
			t.bias = $urandom;
			t.mult = MULT_W'($urandom);
			t.shift = SHIFT_W'($urandom);
		end else begin
			t.bias = int'($urandom_range(0, 32767)) - 16384;
			t.mult = MULT_W'($urandom_range(32'h4000_0000, 32'h7fff_ffff));
			t.shift = SHIFT_W'(int'($urandom_range(0, 12)) - 10);
		end
		return t;
	endfunction

	// one tap transaction, predicted on acceptance
	task automatic send_tap(input tap_t t);
		int gap;
		gap = (tx_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, t.shift, t.mult, t.bias, t.wbyte, t.act};
		s_tuser <= {t.first, t.hi, t.inb};
		s_tlast <= t.last;
		do @(posedge clk); while (!s_tready);
		predict_tap(t);
	endtask

	task automatic send_window(input int len);
		for (int i = 0; i < len; i++)
			send_tap(rand_tap(i == 0, i == len - 1));
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_IN_OFS:  ioff_model = data;
			REG_OUT_OFS: ooff_model = data[OOFF_W-1:0];
			REG_ACT_MIN: min_model = data[OUT_W-1:0];
			REG_ACT_MAX: max_model = data[OUT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_config(input logic [CFG_DATA_W-1:0] ioff, input logic [CFG_DATA_W-1:0] ooff,
		input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi);
		write_reg(REG_IN_OFS, ioff);
		write_reg(REG_OUT_OFS, ooff);
		write_reg(REG_ACT_MIN, lo);
		write_reg(REG_ACT_MAX, hi);
	endtask

	task automatic write_random_config;
		logic [CFG_DATA_W-1:0] lo_lim, hi_lim, swap;
		lo_lim = CFG_DATA_W'($urandom);
		hi_lim = CFG_DATA_W'($urandom);
		if ($urandom_range(0, 7) != 0 && $signed(lo_lim[7:0]) > $signed(hi_lim[7:0])) begin
			swap = lo_lim;
			lo_lim = hi_lim;
			hi_lim = swap;
		end
		write_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), lo_lim, hi_lim);
	endtask

	// reset settings: no first tap after reset, first and last together, held accumulator
	task automatic test_directed_taps;
		send_tap(mk_tap(8'd127, 1, 8'h07, 0, 0, 1, 32'd0, MULT_MAX, 30));
		send_tap(mk_tap(8'h80, 1, 8'h80, 1, 1, 1, 32'h8000_0000, MULT_MAX, 0));
		send_tap(mk_tap(8'h00, 0, 8'hff, 0, 0, 1, 32'd0, MULT_MAX, -32));
		send_tap(mk_tap(8'hff, 0, 8'h5a, 1, 1, 0, 32'h7fff_ffff, 31'd0, 0));
		send_tap(mk_tap(8'd127, 1, 8'hf0, 1, 0, 0, 32'd0, 31'd0, 0));
		send_tap(mk_tap(8'h80, 1, 8'h0f, 0, 0, 1, 32'd0, 31'h4000_0000, -31));
		send_tap(mk_tap(8'd1, 1, 8'h88, 0, 1, 1, 32'd16, MULT_MAX, 31));
		send_tap(mk_tap(8'd55, 1, 8'h3c, 1, 1, 1, -32'sd1000, 31'd0, -4));
		send_tap(mk_tap(8'hb3, 1, 8'h7f, 1, 1, 1, 32'd500000, MULT_MAX, -8));
		drain();
	endtask

	// offset extremes, offset overflow past the clamp, crossed clamp bounds
	task automatic test_config_extremes;
		logic [CFG_DATA_W-1:0] ioffs[4] = '{9'h100, 9'h0ff, 9'h080, 9'h181};
		logic [CFG_DATA_W-1:0] ooffs[4] = '{9'h07f, 9'h180, 9'h07f, 9'h000};
		logic [CFG_DATA_W-1:0] mins[4] = '{9'h080, 9'h080, 9'h180, 9'h064};
		logic [CFG_DATA_W-1:0] maxs[4] = '{9'h07f, 9'h17f, 9'h07f, 9'h19c};
		for (int i = 0; i < 4; i++) begin
			write_config(ioffs[i], ooffs[i], mins[i], maxs[i]);
			send_tap(mk_tap(8'h80, 1, 8'h88, 0, 1, 0, 32'd0, MULT_MAX, 0));
			send_tap(mk_tap(8'h7f, 1, 8'h77, 1, 0, 0, 32'd0, MULT_MAX, 0));
			send_tap(mk_tap(8'hff, 1, 8'h8f, 0, 0, 1, 32'd0, MULT_MAX, -2));
			drain();
		end
	endtask

	// output held off long enough that the block fills and stalls its input
	task automatic test_output_backpressure;
		rx_hold = 400;
		repeat (30) send_window(2);
		drain();
	endtask

	task automatic test_random_windows;
		int sent;
		int len;
		for (int phase = 0; phase < 16; phase++) begin
			write_random_config();
			case ($urandom_range(0, 3))
				0: begin tx_gaps = 1'b1; rx_stalls = 1'b1; end
				1: begin tx_gaps = 1'b1; rx_stalls = 1'b0; end
				2: begin tx_gaps = 1'b0; rx_stalls = 1'b1; end
				default: begin tx_gaps = 1'b0; rx_stalls = 1'b0; end
			endcase
			sent = 0;
			while (sent < 105) begin
				if ($urandom_range(0, 9) == 0) begin
					send_tap(rand_tap(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
					sent++;
				end else begin
					len = $urandom_range(1, 9);
					send_window(len);
					sent += len;
				end
			end
			drain();
		end
	endtask

	task automatic test_full_rate;
		int sent;
		int len;
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		write_random_config();
		sent = 0;
		while (sent < 150) begin
			len = $urandom_range(1, 9);
			send_window(len);
			sent += len;
		end
		drain();
	endtask

	always begin
		@(negedge clk);
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (rx_burst > 0) begin
			rx_burst--;
			m_tready <= 1'b0;
		end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
			rx_burst = $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : out_check
		logic [OUT_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_out.size() == 0) begin
				report_error("output transaction with none pending", 'x, m_tdata);
			end else begin
				want = expected_out.pop_front();
				if (m_tdata !== want)
					report_error("out_value mismatch", want, m_tdata);
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_taps();
		test_config_extremes();
		test_output_backpressure();
		test_random_windows();
		test_full_rate();
		if (errors == 0)
			$display("tb_int4_depthwise_mac_requant: clean");
		else
			$display("tb_int4_depthwise_mac_requant: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_int4_depthwise_mac_requant: errors");
		$finish;
	end

endmodule

[int4_depthwise_mac_requant.f]
rtl/core/i4dw_pkg.sv
rtl/core/i4dw_front.sv
rtl/core/i4dw_queue.sv
rtl/core/i4dw_back.sv
rtl/core/int4_depthwise_mac_requant.sv
rtl/core/i4dw_checker.sv
test/tb_int4_depthwise_mac_requant.sv
